FILE: hdl/sha256_hash_engine_defines.svh
// Assertion macros for the SHA-256 hash engine.
// No dependencies.
`ifndef SHA256_HASH_ENGINE_DEFINES_SVH
`define SHA256_HASH_ENGINE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CHK_IMPL(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define CHK_NEXT(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define CHK_IMPL(lbl, clk, rst, a, c, msg)
`define CHK_NEXT(lbl, clk, rst, a, c, msg)
`endif
`endif

FILE: hdl/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 hash engine.
// No dependencies.
package sha256_pkg;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds = 64;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FILL, ST_PAD, ST_ROUND, ST_ADD, ST_OUT
  } state_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage

FILE: hdl/sha256_round.sv
// One SHA-256 round plus one schedule word, used once per cycle.
// Depends on sha256_pkg.
module sha256_round (
  input  logic [31:0] v_in [8],
  input  logic [31:0] w2,
  input  logic [31:0] w7,
  input  logic [31:0] w15,
  input  logic [31:0] w16,
  input  logic        use_sched,
  input  logic [5:0]  round,
  output logic [31:0] v_out [8],
  output logic [31:0] w_out
);
  logic [31:0] s0, s1, e1, a0, ch, maj, t1, t2;

  always_comb begin
    s1 = sha256_pkg::rotr(w2, 17) ^ sha256_pkg::rotr(w2, 19) ^ (w2 >> 10);
    s0 = sha256_pkg::rotr(w15, 7) ^ sha256_pkg::rotr(w15, 18) ^ (w15 >> 3);
    w_out = use_sched ? (s1 + w7 + s0 + w16) : w16;
    e1 = sha256_pkg::rotr(v_in[4], 6) ^ sha256_pkg::rotr(v_in[4], 11)
       ^ sha256_pkg::rotr(v_in[4], 25);
    ch = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
    a0 = sha256_pkg::rotr(v_in[0], 2) ^ sha256_pkg::rotr(v_in[0], 13)
       ^ sha256_pkg::rotr(v_in[0], 22);
    maj = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
    t1 = v_in[7] + e1 + ch + sha256_pkg::ROUND_K[round] + w_out;
    t2 = a0 + maj;
    v_out[7] = v_in[6];
    v_out[6] = v_in[5];
    v_out[5] = v_in[4];
    v_out[4] = v_in[3] + t1;
    v_out[3] = v_in[2];
    v_out[2] = v_in[1];
    v_out[1] = v_in[0];
    v_out[0] = t1 + t2;
  end
endmodule

FILE: hdl/sha256_hash_engine.sv
// SHA-256 hash engine top level: byte packer, padding sequencer, round loop.
// Depends on sha256_pkg, sha256_round and sha256_hash_engine_defines.svh.
//
// channel  dir  payload
// s_axis   in   tdata {byte_count, data_word}, tlast last_word
// m_axis   out  tdata {word_index, digest_word}, tlast digest_last
//
// A word is accepted, then its valid bytes are packed one by one; a full block
// adds 64 rounds, one per cycle in the shared round unit, then an add step. A
// last word adds one or two padding blocks, a byte per cycle between rounds,
// then eight result words gated by m_axis_tready. Reset is synchronous.
`include "sha256_hash_engine_defines.svh"
module sha256_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] data_word, [34:32] byte_count
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast
);
  sha256_pkg::state_t state, state_next;
  logic [31:0] hash [8];
  logic [31:0] v [8];
  logic [31:0] v_new [8];
  logic [31:0] win [16];
  logic [5:0]  bytes_held;
  logic [60:0] message_bytes;
  logic [31:0] word;
  logic [2:0]  left;
  logic        last;
  logic [1:0]  bpos;
  logic [5:0]  round;
  logic [3:0]  pad_len;
  logic        pad_started;
  logic [2:0]  out_idx;
  logic [31:0] w_new;
  logic [63:0] bits;
  logic [7:0]  pad_b;
  logic        push;
  logic [7:0]  push_b;
  logic        fill_done;
  logic [2:0]  cnt_in;
  logic [3:0]  ri;

  assign bits = {message_bytes, 3'b000};
  assign ri = round[3:0];

  sha256_round u_round (
    .v_in(v), .w2(win[ri - 4'd2]), .w7(win[ri - 4'd7]), .w15(win[ri - 4'd15]),
    .w16(win[ri]), .use_sched(round >= 6'd16), .round(round),
    .v_out(v_new), .w_out(w_new)
  );

  assign cnt_in = (s_axis_tdata[34:32] > 3'd4) ? 3'd4 : s_axis_tdata[34:32];
  assign s_axis_tready = (state == sha256_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      sha256_pkg::ST_IDLE:
        if (s_axis_tvalid) state_next = (cnt_in != 3'd0) ? sha256_pkg::ST_FILL
                                      : (s_axis_tlast ? sha256_pkg::ST_PAD
                                      : sha256_pkg::ST_IDLE);
      sha256_pkg::ST_FILL:
        if (bytes_held == 6'd63) state_next = sha256_pkg::ST_ROUND;
        else if (left == 3'd1) state_next = last ? sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
      sha256_pkg::ST_PAD:
        if (bytes_held == 6'd63) state_next = sha256_pkg::ST_ROUND;
      sha256_pkg::ST_ROUND:
        if (round == 6'd63) state_next = sha256_pkg::ST_ADD;
      sha256_pkg::ST_ADD:
        state_next = fill_done ? sha256_pkg::ST_OUT
                   : (left != 3'd0) ? sha256_pkg::ST_FILL
                   : last ? sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
      sha256_pkg::ST_OUT:
        if (m_axis_tready && out_idx == 3'd7) state_next = sha256_pkg::ST_IDLE;
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pad_b = 8'h00;
    if (!pad_started) pad_b = sha256_pkg::PAD_BYTE;
    else if (pad_len != 4'd0) pad_b = bits[8 * (pad_len - 4'd1) +: 8];
    push = (state == sha256_pkg::ST_FILL) || (state == sha256_pkg::ST_PAD);
    push_b = (state == sha256_pkg::ST_FILL) ? word[31 - 8 * bpos -: 8] : pad_b;
  end

  assign m_axis_tvalid = (state == sha256_pkg::ST_OUT);
  assign m_axis_tdata = {5'd0, out_idx, hash[out_idx]};
  assign m_axis_tlast = (out_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::ST_IDLE;
      for (int i = 0; i < 8; i++) hash[i] <= sha256_pkg::INIT_HASH[i];
      bytes_held <= '0;
      message_bytes <= '0;
      left <= '0;
      last <= 1'b0;
      bpos <= '0;
      round <= '0;
      pad_len <= '0;
      pad_started <= 1'b0;
      out_idx <= '0;
      fill_done <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        sha256_pkg::ST_IDLE:
          if (s_axis_tvalid) begin
            word <= s_axis_tdata[31:0];
            left <= cnt_in;
            last <= s_axis_tlast;
            bpos <= '0;
            pad_started <= 1'b0;
            pad_len <= 4'd0;
            fill_done <= 1'b0;
          end
        sha256_pkg::ST_FILL: begin
          bytes_held <= bytes_held + 6'd1;
          message_bytes <= message_bytes + 61'd1;
          left <= left - 3'd1;
          bpos <= bpos + 2'd1;
        end
        sha256_pkg::ST_PAD: begin
          bytes_held <= bytes_held + 6'd1;
          pad_started <= 1'b1;
          if (pad_started && pad_len != 4'd0) pad_len <= pad_len - 4'd1;
          if (bytes_held + 6'd1 == sha256_pkg::LEN_POS) pad_len <= 4'd8;
          if (pad_len == 4'd1) fill_done <= 1'b1;
        end
        sha256_pkg::ST_ADD:
          for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
        sha256_pkg::ST_OUT:
          if (m_axis_tready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) hash[i] <= sha256_pkg::INIT_HASH[i];
              bytes_held <= '0;
              message_bytes <= '0;
            end
          end
        default: ;
      endcase
      if (state_next == sha256_pkg::ST_ROUND && state != sha256_pkg::ST_ROUND) round <= '0;
      else if (state == sha256_pkg::ST_ROUND) round <= round + 6'd1;
    end
  end

  // bytes pack straight into the schedule window, top byte of each word first
  always_ff @(posedge clk) begin
    if (push) win[bytes_held[5:2]][{~bytes_held[1:0], 3'b000} +: 8] <= push_b;
    else if (state == sha256_pkg::ST_ROUND) win[ri] <= w_new;
  end

  always_ff @(posedge clk) begin
    if (state != sha256_pkg::ST_ROUND && state_next == sha256_pkg::ST_ROUND) v <= hash;
    else if (state == sha256_pkg::ST_ROUND) v <= v_new;
  end

  `CHK_IMPL(a_busy_no_ready, clk, rst, state != sha256_pkg::ST_IDLE, !s_axis_tready, "ready while busy")
  `CHK_IMPL(a_last_idx, clk, rst, m_axis_tvalid && m_axis_tlast, out_idx == 3'd7, "bad last")
  `CHK_NEXT(a_out_reset, clk, rst, m_axis_tvalid && m_axis_tready && m_axis_tlast, bytes_held == 6'd0 && message_bytes == 61'd0, "no restart")
endmodule
